[sv/lcct_pkg.sv]
// shared types and constants for the least count contact table
`default_nettype none
package lcct_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [1:0] STATUS_STORED   = 2'd0;
  localparam logic [1:0] STATUS_ADDED    = 2'd1;
  localparam logic [1:0] STATUS_REPLACED = 2'd2;
  localparam logic [1:0] STATUS_CLEARED  = 2'd3;

  typedef enum logic {
    OP_ADD,
    OP_CLEAR
  } lcct_op_t;

  typedef struct packed {
    logic        cmd;
    logic        is_client;
    logic [31:0] peer_addr;
    logic [31:0] increment;
  } lcct_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] evicted_addr;
    logic [31:0] evicted_count;
    logic        evicted_is_client;
  } lcct_out_t;

  typedef struct packed {
    lcct_op_t    op;
    logic        is_client;
    logic [31:0] peer_addr;
    logic [31:0] increment;
  } lcct_job_t;

endpackage
`default_nettype wire

[sv/lcct_fifo.sv]
// small two-entry queue carrying one packed beat type
`default_nettype none
module lcct_fifo #(
  parameter type T = logic
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic      full,
  input  wire T     wr_data,
  input  wire logic pop,
  output logic      empty,
  output T          rd_data
);
  import lcct_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  T                buf_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [NW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == NW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/lcct_front.sv]
// front end: accepts input beats, classifies them and queues jobs
`default_nettype none
module lcct_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire lcct_pkg::lcct_in_t in_data,
  input  wire logic              job_pop,
  output logic                   job_empty,
  output lcct_pkg::lcct_job_t    job
);
  import lcct_pkg::*;

  lcct_job_t job_in;

  always_comb begin
    job_in.op        = (in_data.cmd == CMD_CLEAR) ? OP_CLEAR : OP_ADD;
    job_in.is_client = in_data.is_client;
    job_in.peer_addr = in_data.peer_addr;
    job_in.increment = in_data.increment;
  end

  lcct_fifo #(
    .T(lcct_job_t)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .wr_data (job_in),
    .pop     (job_pop),
    .empty   (job_empty),
    .rd_data (job)
  );

endmodule
`default_nettype wire

[sv/lcct_back.sv]
// back end: table memory and sequential scan that carries out each job
`default_nettype none
module lcct_back #(
  parameter int unsigned ENTRIES = lcct_pkg::ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               job_empty,
  output logic                    job_pop,
  input  wire lcct_pkg::lcct_job_t job,
  input  wire logic               res_full,
  output logic                    res_push,
  output lcct_pkg::lcct_out_t     res
);
  import lcct_pkg::*;

  localparam int unsigned SW    = $clog2(ENTRIES);
  localparam int unsigned CW    = $clog2(ENTRIES + 1);
  localparam int unsigned AW    = SW + 1;
  localparam int unsigned DEPTH = 1 << AW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t        state_r;
  lcct_job_t     job_r;
  lcct_out_t     res_r;
  logic [63:0]   mem_r [DEPTH];
  logic [63:0]   rd_data_r;
  logic [CW-1:0] rd_idx_r;
  logic          ev_vld_r;
  logic [SW-1:0] ev_idx_r;
  logic [SW-1:0] least_idx_r;
  logic [31:0]   least_cnt_r;
  logic [31:0]   least_addr_r;
  logic [CW-1:0] fill_r [2];

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic [CW-1:0] cur_fill;
  logic          cur_used;
  logic [31:0]   cur_addr;
  logic [31:0]   cur_cnt;
  logic          is_empty;
  logic          is_match;
  logic          is_last;
  logic          take_least;
  logic [SW-1:0] lst_idx;
  logic [31:0]   lst_cnt;
  logic [31:0]   lst_addr;
  logic          hit;
  logic [32:0]   sum;
  logic [31:0]   sat_sum;

  assign cur_fill   = fill_r[job_r.is_client];
  assign cur_used   = CW'(ev_idx_r) < cur_fill;
  assign cur_addr   = rd_data_r[63:32];
  assign cur_cnt    = cur_used ? rd_data_r[31:0] : '0;
  assign is_empty   = (cur_cnt == '0);
  assign is_match   = (cur_addr == job_r.peer_addr);
  assign is_last    = (ev_idx_r == SW'(ENTRIES - 1));
  assign take_least = (ev_idx_r == '0) || (cur_cnt < least_cnt_r);
  assign lst_idx    = take_least ? ev_idx_r : least_idx_r;
  assign lst_cnt    = take_least ? cur_cnt : least_cnt_r;
  assign lst_addr   = take_least ? cur_addr : least_addr_r;
  assign hit        = (state_r == S_SCAN) && ev_vld_r && (is_empty || is_match || is_last);
  assign sum        = {1'b0, cur_cnt} + {1'b0, job_r.increment};
  assign sat_sum    = sum[32] ? '1 : sum[31:0];

  assign rd_en   = (state_r == S_SCAN) && (rd_idx_r < CW'(ENTRIES)) && !hit;
  assign rd_addr = {job_r.is_client, rd_idx_r[SW-1:0]};

  always_comb begin
    wr_en   = hit;
    wr_addr = {job_r.is_client, ev_idx_r};
    wr_data = {job_r.peer_addr, job_r.increment};
    if (!is_empty && is_match) begin
      wr_data = {cur_addr, sat_sum};
    end else if (!is_empty) begin
      wr_addr = {job_r.is_client, lst_idx};
    end
  end

  assign job_pop  = (state_r == S_IDLE) && !job_empty;
  assign res_push = (state_r == S_RESULT) && !res_full;
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_idx_r  <= '0;
      ev_vld_r  <= 1'b0;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            job_r    <= job;
            rd_idx_r <= '0;
            ev_vld_r <= 1'b0;
            if (job.op == OP_CLEAR) begin
              fill_r[0]               <= '0;
              fill_r[1]               <= '0;
              res_r.status            <= STATUS_CLEARED;
              res_r.evicted_addr      <= '0;
              res_r.evicted_count     <= '0;
              res_r.evicted_is_client <= 1'b0;
              state_r                 <= S_RESULT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          ev_vld_r <= rd_en;
          ev_idx_r <= rd_idx_r[SW-1:0];
          if (rd_en) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
          if (ev_vld_r) begin
            least_idx_r  <= lst_idx;
            least_cnt_r  <= lst_cnt;
            least_addr_r <= lst_addr;
          end
          if (hit) begin
            res_r.evicted_addr      <= '0;
            res_r.evicted_count     <= '0;
            res_r.evicted_is_client <= 1'b0;
            if (is_empty) begin
              res_r.status <= STATUS_STORED;
              if (CW'(ev_idx_r) == cur_fill) begin
                fill_r[job_r.is_client] <= cur_fill + 1'b1;
              end
            end else if (is_match) begin
              res_r.status <= STATUS_ADDED;
            end else begin
              res_r.status            <= STATUS_REPLACED;
              res_r.evicted_addr      <= lst_addr;
              res_r.evicted_count     <= lst_cnt;
              res_r.evicted_is_client <= job_r.is_client;
            end
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!res_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/least_count_contact_table_unit.sv]
// top level of the least count contact table
// Two tables of ENTRIES slots (server and client) hold peer addresses with contact
// counts in one on-chip memory. Input beats go into a two-entry job queue and
// results come out of a two-entry result queue. An add beat scans its table one
// slot per cycle through the memory read port, stopping early when an empty or
// matching slot turns up; a clear beat needs no scan, since per-table fill counts
// mark every slot empty at once. No clearing pass after reset is needed.
`default_nettype none
module least_count_contact_table_unit #(
  parameter int unsigned ENTRIES = lcct_pkg::ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire lcct_pkg::lcct_in_t in_data,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output lcct_pkg::lcct_out_t     out_data
);
  import lcct_pkg::*;

  logic      job_empty;
  logic      job_pop;
  lcct_job_t job;
  logic      res_full;
  logic      res_push;
  lcct_out_t res;

  lcct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .job_pop   (job_pop),
    .job_empty (job_empty),
    .job       (job)
  );

  lcct_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  lcct_fifo #(
    .T(lcct_out_t)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .full    (res_full),
    .wr_data (res),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (out_data)
  );

endmodule
`default_nettype wire
